>>> rtl/slb_pkg.sv
// ----------------------------------------------------------------------------
// slb_pkg: shared types and constants for the segment lookaside buffer
// Entry layout, action codes, controller states and the table port structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slb_pkg;

	// Table size and derived index widths
	localparam int ENTRIES     = 64;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int IDX_FIELD_W = 12;
	localparam int SR_W        = 4;

	// Field widths
	localparam int ESID_W = 36;
	localparam int VSID_W = 52;
	localparam int FLAG_W = 5;
	localparam int WORD_W = 64;
	localparam int ACT_W  = 4;

	// Bit positions in the instruction operands
	localparam int A_ESID_LSB   = 28;
	localparam int A_CLASS_BIT  = 27;
	localparam int B_VALID_BIT  = 36;
	localparam int B_IDX_LSB    = 52;
	localparam int B_SEG_LSB    = 32;
	localparam int S_FLAG_LSB   = 52;
	localparam int SR_FLAG_LSB  = 33;
	localparam int SR_VSID_LSB  = 37;
	localparam int SR_VSID_SHFT = 25;
	localparam int SR_VSID_W    = 27;
	localparam int C_FLAG_BIT   = 4;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_INV_ALL  = 4'd0;
	localparam logic [ACT_W-1:0] ACT_INV_ENT  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE    = 4'd2;
	localparam logic [ACT_W-1:0] ACT_RD_ESID  = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RD_VSID  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_MTSR     = 4'd5;
	localparam logic [ACT_W-1:0] ACT_MTSRIN   = 4'd6;
	localparam logic [ACT_W-1:0] ACT_MFSR     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_MFSRIN   = 4'd8;

	// One table entry (valid bit is kept in its own memory)
	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic [VSID_W-1:0] vsid;
		logic [ESID_W-1:0] esid;
	} entry_t;

	// Table access request: one read port, one write port
	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we_entry;
		logic             we_valid;
		logic [IDX_W-1:0] waddr;
		entry_t           wentry;
		logic             wvalid;
	} mem_req_t;

	// Registered read data
	typedef struct packed {
		entry_t entry;
		logic   valid;
	} mem_rsp_t;

	// Result word
	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic              writes_register;
		logic              illegal_instruction;
	} result_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_INV_ALL,
		ST_INV_SCAN,
		ST_INV_DRAIN,
		ST_RD_DATA,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

>>> rtl/slb_if.sv
// ----------------------------------------------------------------------------
// slb_if: instruction and result channels of the segment lookaside buffer
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface slb_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [63:0] reg_a_value;
	logic [63:0] reg_b_value;
	logic [63:0] reg_s_value;
	logic [3:0]  segment_number;

	modport source (output valid, action, reg_a_value, reg_b_value, reg_s_value,
		segment_number, input ready);
	modport sink (input valid, action, reg_a_value, reg_b_value, reg_s_value,
		segment_number, output ready);
endinterface

interface slb_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_value;
	logic        writes_register;
	logic        illegal_instruction;

	modport source (output valid, read_value, writes_register, illegal_instruction,
		input ready);
	modport sink (input valid, read_value, writes_register, illegal_instruction,
		output ready);
endinterface

`default_nettype wire

>>> rtl/segment_lookaside_buffer.sv
// ----------------------------------------------------------------------------
// segment_lookaside_buffer: segment entry table with instruction port
// Executes one segment instruction per request word, one result word each.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one instruction word (action, registers A/B/S, segment
//   number); rsp returns one result word per instruction (read value,
//   register write flag, illegal flag). Words move on valid && ready.
//   One instruction is in work at a time. From accept, each one
//   steps through these controller states, then back to IDLE:
//     writes, moves to segment, unknown actions: EXEC, RESP
//     reads, moves from segment (in range): EXEC, RD_DATA, RESP
//     invalidate all: EXEC, INV_ALL, RESP
//     invalidate entry: EXEC, INV_SCAN, INV_DRAIN, RESP
//   The steps come from the entry memory with one write and one
//   registered read port: a read costs one access plus its registered data,
//   invalidates sweep every entry, one per cycle.
//   After reset the controller sweeps the memories to zero, one entry per
//   cycle, with req.ready low. The result sits in an output register; a
//   new instruction is taken while it waits, and a finished result that
//   finds the register still full holds until rsp.ready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lookaside_buffer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slb_req_if.sink    req,
	slb_rsp_if.source  rsp
);
	import slb_pkg::*;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    cnt_q;
	logic                cnt_last;
	logic                cnt_run;
	logic [ACT_W-1:0]    act_q;
	logic [WORD_W-1:0]   a_q, b_q, s_q;
	logic [SR_W-1:0]     sr_q;
	logic                scan_v_s1;
	logic [IDX_W-1:0]    scan_addr_s1;
	result_t             res_q, res_d;
	logic                res_load;
	result_t             out_q;
	logic                out_valid_q;
	logic                out_load;
	logic                in_ready;
	mem_req_t            mem_req;
	mem_rsp_t            mem_rsp;
	logic [IDX_FIELD_W-1:0] idx_sel;
	logic                idx_oob;
	logic [IDX_W-1:0]    idx_addr;
	logic                is_read;
	logic                scan_hit;

	slb_table u_table (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	// Index selection for the latched instruction
	always_comb begin
		case (act_q)
			ACT_WRITE:                idx_sel = b_q[B_IDX_LSB +: IDX_FIELD_W];
			ACT_RD_ESID, ACT_RD_VSID: idx_sel = b_q[IDX_FIELD_W-1:0];
			ACT_MTSR, ACT_MFSR:       idx_sel = IDX_FIELD_W'(sr_q);
			ACT_MTSRIN, ACT_MFSRIN:   idx_sel = IDX_FIELD_W'(b_q[B_SEG_LSB +: SR_W]);
			default:                  idx_sel = '0;
		endcase
	end

	assign idx_oob  = {1'b0, idx_sel} >= (IDX_FIELD_W+1)'(ENTRIES);
	assign idx_addr = idx_sel[IDX_W-1:0];
	assign is_read  = (act_q == ACT_RD_ESID) || (act_q == ACT_RD_VSID) ||
		(act_q == ACT_MFSR) || (act_q == ACT_MFSRIN);
	assign cnt_last = (cnt_q == IDX_W'(ENTRIES - 1));

	// Invalidate-entry match on the entry read in the cycle before
	assign scan_hit = scan_v_s1 && mem_rsp.valid &&
		(mem_rsp.entry.esid == a_q[A_ESID_LSB +: ESID_W]) &&
		(mem_rsp.entry.flags[C_FLAG_BIT] == a_q[A_CLASS_BIT]);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:     if (cnt_last) state_d = ST_IDLE;
			ST_IDLE:      if (req.valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (act_q == ACT_INV_ALL) begin
					state_d = ST_INV_ALL;
				end else if (act_q == ACT_INV_ENT) begin
					state_d = ST_INV_SCAN;
				end else if (is_read && !idx_oob) begin
					state_d = ST_RD_DATA;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_INV_ALL:   if (cnt_last) state_d = ST_RESP;
			ST_INV_SCAN:  if (cnt_last) state_d = ST_INV_DRAIN;
			ST_INV_DRAIN: state_d = ST_RESP;
			ST_RD_DATA:   state_d = ST_RESP;
			ST_RESP:      if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the controller: table requests, result, handshakes
	always_comb begin
		mem_req  = '0;
		res_d    = '0;
		res_load = 1'b0;
		cnt_run  = 1'b0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we_entry = 1'b1;
				mem_req.we_valid = 1'b1;
				mem_req.waddr    = cnt_q;
				cnt_run          = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EXEC: begin
				res_load                  = 1'b1;
				res_d.illegal_instruction = idx_oob;
				case (act_q)
					ACT_WRITE: begin
						mem_req.we_entry     = !idx_oob;
						mem_req.we_valid     = !idx_oob;
						mem_req.waddr        = idx_addr;
						mem_req.wvalid       = b_q[B_VALID_BIT];
						mem_req.wentry.esid  = b_q[ESID_W-1:0];
						mem_req.wentry.vsid  = s_q[VSID_W-1:0];
						mem_req.wentry.flags = s_q[S_FLAG_LSB +: FLAG_W];
					end
					ACT_MTSR, ACT_MTSRIN: begin
						mem_req.we_entry     = !idx_oob;
						mem_req.we_valid     = !idx_oob;
						mem_req.waddr        = idx_addr;
						mem_req.wvalid       = 1'b1;
						mem_req.wentry.esid  = ESID_W'({idx_sel[SR_W-1:0], 32'b0});
						mem_req.wentry.vsid  = {s_q[SR_VSID_LSB +: SR_VSID_W],
							SR_VSID_SHFT'(0)};
						mem_req.wentry.flags = {1'b0, s_q[SR_FLAG_LSB +: FLAG_W-1]};
					end
					ACT_RD_ESID, ACT_RD_VSID, ACT_MFSR, ACT_MFSRIN: begin
						mem_req.re    = !idx_oob;
						mem_req.raddr = idx_addr;
					end
					default: begin
					end
				endcase
			end
			ST_INV_ALL: begin
				mem_req.we_valid = 1'b1;
				mem_req.waddr    = cnt_q;
				cnt_run          = 1'b1;
			end
			ST_INV_SCAN: begin
				mem_req.re       = 1'b1;
				mem_req.raddr    = cnt_q;
				mem_req.we_valid = scan_hit;
				mem_req.waddr    = scan_addr_s1;
				cnt_run          = 1'b1;
			end
			ST_INV_DRAIN: begin
				mem_req.we_valid = scan_hit;
				mem_req.waddr    = scan_addr_s1;
			end
			ST_RD_DATA: begin
				res_load              = 1'b1;
				res_d.writes_register = 1'b1;
				case (act_q)
					ACT_RD_ESID: res_d.read_value = WORD_W'({mem_rsp.valid,
						mem_rsp.entry.esid});
					ACT_RD_VSID: res_d.read_value = WORD_W'({mem_rsp.entry.flags,
						mem_rsp.entry.vsid});
					default: res_d.read_value = {
						mem_rsp.entry.vsid[SR_VSID_SHFT +: SR_VSID_W],
						mem_rsp.entry.flags[FLAG_W-2:0], SR_FLAG_LSB'(0)};
				endcase
			end
			ST_RESP: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == ST_INV_SCAN);
			if (cnt_run) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			act_q <= req.action;
			a_q   <= req.reg_a_value;
			b_q   <= req.reg_b_value;
			s_q   <= req.reg_s_value;
			sr_q  <= req.segment_number;
		end
		scan_addr_s1 <= cnt_q;
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign req.ready               = in_ready;
	assign rsp.valid               = out_valid_q;
	assign rsp.read_value          = out_q.read_value;
	assign rsp.writes_register     = out_q.writes_register;
	assign rsp.illegal_instruction = out_q.illegal_instruction;

	// Checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mem_req.we_entry || mem_req.we_valid))
		else $error("table written while idle");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result appeared outside the response state");

	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_DATA) |-> $past(mem_req.re))
		else $error("read data used without a read");

	a_illegal_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.illegal_instruction && out_q.writes_register))
		else $error("illegal instruction flagged a register write");

endmodule

`default_nettype wire

>>> rtl/slb_table.sv
// ----------------------------------------------------------------------------
// slb_table: entry storage
// Entry memory and valid-bit memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slb_table (
	input  wire                logic clk,
	input  wire slb_pkg::mem_req_t req,
	output slb_pkg::mem_rsp_t  rsp
);
	import slb_pkg::*;

	entry_t   entry_mem [ENTRIES];
	logic     valid_mem [ENTRIES];
	mem_rsp_t rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.we_entry) begin
			entry_mem[req.waddr] <= req.wentry;
		end
		if (req.we_valid) begin
			valid_mem[req.waddr] <= req.wvalid;
		end
	end

	// Read port, registered data
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q.entry <= entry_mem[req.raddr];
			rd_q.valid <= valid_mem[req.raddr];
		end
	end

	assign rsp = rd_q;

endmodule

`default_nettype wire

>>> bench/tb_segment_lookaside_buffer.sv
// ----------------------------------------------------------------------------
// tb_segment_lookaside_buffer: self-checking bench for the segment table
// A directed run over the edge cases, then random instruction streams that
// reuse a small set of segment ids and indexes so that invalidates hit. A
// behavioral copy of the table predicts every result word; both channels
// stall at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_lookaside_buffer;
	import slb_pkg::*;

	// Bench constants
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_OPS     = 800;
	localparam int TAIL_OPS       = 120;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AFTER     = 300;
	localparam int MAX_REPORTS    = 10;
	localparam int ESID_POOL_N    = 12;

	// Actions the block does not decode
	localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 4'd9;
	localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 4'd15;

	// One instruction word
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] s;
		logic [SR_W-1:0]   sr;
	} slb_op_t;

	logic clk = 1'b0;
	logic arst_n;

	slb_req_if req_ch ();
	slb_rsp_if rsp_ch ();

	segment_lookaside_buffer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the segment table
	logic              tbl_valid [ENTRIES];
	logic [ESID_W-1:0] tbl_esid  [ENTRIES];
	logic [VSID_W-1:0] tbl_vsid  [ENTRIES];
	logic [FLAG_W-1:0] tbl_flags [ENTRIES];

	slb_op_t           pending_ops [$];
	result_t           results_due [$];
	logic [ESID_W-1:0] esid_pool [ESID_POOL_N];

	int ops_total    = 0;
	int ops_accepted = 0;
	int results_seen = 0;
	int slb_errors   = 0;
	int reports      = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	int long_hold    = 0;
	int quiet_cycles = 0;
	bit long_hold_done = 1'b0;

	// Execute one instruction on the shadow table, return its result word
	function automatic result_t execute_slb_op(input slb_op_t op);
		result_t           res;
		logic [11:0]       idx;
		logic [IDX_W-1:0]  ix;
		logic [ESID_W-1:0] esid_key;
		logic              cls;
		res = '0;
		case (op.action)
			ACT_INV_ALL: begin
				for (int i = 0; i < ENTRIES; i++)
					tbl_valid[i] = 1'b0;
			end
			ACT_INV_ENT: begin
				esid_key = op.a[A_ESID_LSB +: ESID_W];
				cls      = op.a[A_CLASS_BIT];
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_esid[i] == esid_key &&
							tbl_flags[i][C_FLAG_BIT] == cls)
						tbl_valid[i] = 1'b0;
			end
			ACT_WRITE: begin
				idx = op.b[B_IDX_LSB +: IDX_FIELD_W];
				if (idx >= ENTRIES) begin
					res.illegal_instruction = 1'b1;
				end else begin
					ix = idx[IDX_W-1:0];
					tbl_valid[ix] = op.b[B_VALID_BIT];
					tbl_esid[ix]  = op.b[ESID_W-1:0];
					tbl_vsid[ix]  = op.s[VSID_W-1:0];
					tbl_flags[ix] = op.s[S_FLAG_LSB +: FLAG_W];
				end
			end
			ACT_RD_ESID, ACT_RD_VSID: begin
				idx = op.b[IDX_FIELD_W-1:0];
				if (idx >= ENTRIES) begin
					res.illegal_instruction = 1'b1;
				end else begin
					ix = idx[IDX_W-1:0];
					res.writes_register = 1'b1;
					if (op.action == ACT_RD_ESID)
						res.read_value = {27'd0, tbl_valid[ix], tbl_esid[ix]};
					else
						res.read_value = {7'd0, tbl_flags[ix], tbl_vsid[ix]};
				end
			end
			ACT_MTSR, ACT_MTSRIN: begin
				idx = (op.action == ACT_MTSR) ? 12'(op.sr) : 12'(op.b[B_SEG_LSB +: SR_W]);
				if (idx >= ENTRIES) begin
					res.illegal_instruction = 1'b1;
				end else begin
					// segment view: esid from the number, upper vsid bits, C cleared
					ix = idx[IDX_W-1:0];
					tbl_valid[ix] = 1'b1;
					tbl_esid[ix]  = {ix[SR_W-1:0], 32'd0};
					tbl_vsid[ix]  = {op.s[SR_VSID_LSB +: SR_VSID_W], 25'd0};
					tbl_flags[ix] = {1'b0, op.s[SR_FLAG_LSB +: 4]};
				end
			end
			ACT_MFSR, ACT_MFSRIN: begin
				idx = (op.action == ACT_MFSR) ? 12'(op.sr) : 12'(op.b[B_SEG_LSB +: SR_W]);
				if (idx >= ENTRIES) begin
					res.illegal_instruction = 1'b1;
				end else begin
					ix = idx[IDX_W-1:0];
					res.writes_register = 1'b1;
					res.read_value = {tbl_vsid[ix][VSID_W-1 -: SR_VSID_W],
						tbl_flags[ix][3:0], 33'd0};
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic slb_op_t make_op(input logic [ACT_W-1:0] action,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
			input logic [WORD_W-1:0] s, input logic [SR_W-1:0] sr);
		slb_op_t op;
		op.action = action;
		op.a      = a;
		op.b      = b;
		op.s      = s;
		op.sr     = sr;
		return op;
	endfunction

	function automatic logic [WORD_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly the low sixteen entries so segment moves and writes collide
	function automatic logic [11:0] pick_index();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 12'($urandom_range(ENTRIES, 4095));
		else if (r == 1)
			return ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'(ENTRIES);
		else if (r < 5)
			return 12'($urandom_range(0, ENTRIES - 1));
		else
			return 12'($urandom_range(0, 15));
	endfunction

	// Random instruction with fields steered toward hits
	function automatic slb_op_t random_slb_op();
		slb_op_t op;
		int      r;
		op = make_op(ACT_INV_ALL, rand64(), rand64(), rand64(), 4'($urandom));
		r = $urandom_range(0, 31);
		if (r == 0) begin
			op.action = ACT_INV_ALL;
		end else if (r < 5) begin
			op.action = ACT_INV_ENT;
			if ($urandom_range(0, 7) != 0)
				op.a[WORD_W-1:A_ESID_LSB] = esid_pool[$urandom_range(0, ESID_POOL_N - 1)];
		end else if (r < 12) begin
			op.action = ACT_WRITE;
			op.b[B_IDX_LSB +: IDX_FIELD_W] = pick_index();
			op.b[B_VALID_BIT] = ($urandom_range(0, 5) != 0);
			op.b[ESID_W-1:0] = esid_pool[$urandom_range(0, ESID_POOL_N - 1)];
		end else if (r < 20) begin
			op.action = (r < 16) ? ACT_RD_ESID : ACT_RD_VSID;
			op.b[IDX_FIELD_W-1:0] = pick_index();
		end else if (r < 23) begin
			op.action = ACT_MTSR;
		end else if (r < 26) begin
			op.action = ACT_MTSRIN;
		end else if (r < 28) begin
			op.action = ACT_MFSR;
		end else if (r < 30) begin
			op.action = ACT_MFSRIN;
		end else begin
			op.action = 4'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
		end
		return op;
	endfunction

	// Stimulus, reset and end of run
	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.action         = ACT_INV_ALL;
		req_ch.reg_a_value    = '0;
		req_ch.reg_b_value    = '0;
		req_ch.reg_s_value    = '0;
		req_ch.segment_number = '0;
		rsp_ch.ready          = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_esid[i]  = '0;
			tbl_vsid[i]  = '0;
			tbl_flags[i] = '0;
		end

		// segment ids shared by writes and invalidates
		esid_pool[0] = '1;
		esid_pool[1] = '0;
		esid_pool[2] = {4'd3, 32'd0};
		esid_pool[3] = {4'd15, 32'd0};
		for (int i = 4; i < ESID_POOL_N; i++)
			esid_pool[i] = {$urandom, $urandom};

		// directed: empty table, extreme indexes, class match, segment view
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, '0, '0, '0));
		pending_ops.push_back(make_op(ACT_WRITE, '0, {12'd0, 15'h7fff, 1'b1, 36'hf_ffff_ffff},
			'1, '0));
		pending_ops.push_back(make_op(ACT_WRITE, '0, {12'd63, 15'd0, 1'b1, 36'h1_2345_6789},
			64'hfe0a_aaaa_aaaa_aaaa, '0));
		pending_ops.push_back(make_op(ACT_WRITE, '0, {12'd64, 52'h0_0000_0000_0001}, '1, '0));
		pending_ops.push_back(make_op(ACT_WRITE, '0, '1, '1, '1));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, {{52{1'b1}}, 12'd63}, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_VSID, '0, 64'd63, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_VSID, '1, 64'd0, '1, '1));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, 64'd64, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_VSID, '0, '1, '0, '0));
		pending_ops.push_back(make_op(ACT_INV_ENT, '1, '0, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, 64'd0, '0, '0));
		pending_ops.push_back(make_op(ACT_MTSR, '0, '0, '1, 4'd15));
		pending_ops.push_back(make_op(ACT_MFSR, '0, '0, '0, 4'd15));
		pending_ops.push_back(make_op(ACT_MTSRIN, '1, {28'h0, 4'd0, 32'hffff_ffff},
			64'haaaa_aaaa_aaaa_aaaa, '0));
		pending_ops.push_back(make_op(ACT_MFSRIN, '0, {28'hfff_ffff, 4'd0, 32'hffff_ffff},
			'0, '1));
		pending_ops.push_back(make_op(ACT_MFSRIN, '0, {28'h0, 4'hf, 32'h0}, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, 64'd15, '0, '0));
		// esid of segment 15, class 0: clears that entry
		pending_ops.push_back(make_op(ACT_INV_ENT, {4'hf, 32'd0, 1'b0, 27'h7ff_ffff}, '0, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, 64'd15, '0, '0));
		pending_ops.push_back(make_op(ACT_INV_ALL, '0, '0, '0, '0));
		pending_ops.push_back(make_op(ACT_RD_ESID, '0, 64'd63, '0, '0));
		pending_ops.push_back(make_op(ACT_MFSRIN, '0, '0, '0, '0));
		pending_ops.push_back(make_op(ACT_RSVD_FIRST, rand64(), rand64(), rand64(), '1));
		pending_ops.push_back(make_op(ACT_RSVD_LAST, '1, '1, '1, '1));

		for (int i = 0; i < RANDOM_OPS; i++)
			pending_ops.push_back(random_slb_op());
		ops_total = pending_ops.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_accepted != ops_total || results_due.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		if (results_due.size() != 0)
			slb_errors++;

		if (slb_errors == 0)
			$display("segment_lookaside_buffer test passed");
		else
			$display("segment_lookaside_buffer test failed");
		$finish;
	end

	// Instruction driver: predicts on acceptance, idles in random bursts
	always @(posedge clk) begin
		slb_op_t nxt;
		logic    offer;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				nxt = make_op(req_ch.action, req_ch.reg_a_value, req_ch.reg_b_value,
					req_ch.reg_s_value, req_ch.segment_number);
				results_due.push_back(execute_slb_op(nxt));
				ops_accepted++;
			end
			offer = req_ch.valid && !req_ch.ready;
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0) begin
					if (pending_ops.size() > TAIL_OPS && $urandom_range(0, 9) == 0) begin
						send_gap = $urandom_range(0, 11);
					end else begin
						nxt   = pending_ops.pop_front();
						offer = 1'b1;
						req_ch.action         <= nxt.action;
						req_ch.reg_a_value    <= nxt.a;
						req_ch.reg_b_value    <= nxt.b;
						req_ch.reg_s_value    <= nxt.s;
						req_ch.segment_number <= nxt.sr;
					end
				end
			end
			req_ch.valid <= offer;
		end
	end

	// Result monitor and receiver back-pressure
	always @(posedge clk) begin
		result_t got;
		result_t want;
		logic    stall;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_value          = rsp_ch.read_value;
				got.writes_register     = rsp_ch.writes_register;
				got.illegal_instruction = rsp_ch.illegal_instruction;
				if (results_due.size() == 0) begin
					slb_errors++;
					reports++;
					if (reports <= MAX_REPORTS)
						$display("unexpected result word: rv=%h wr=%b ill=%b", got.read_value,
							got.writes_register, got.illegal_instruction);
				end else begin
					want = results_due.pop_front();
					if (got.read_value !== want.read_value ||
							got.writes_register !== want.writes_register ||
							got.illegal_instruction !== want.illegal_instruction) begin
						slb_errors++;
						reports++;
						if (reports <= MAX_REPORTS)
							$display("result %0d mismatch: expected rv=%h wr=%b ill=%b, got rv=%h wr=%b ill=%b",
								results_seen, want.read_value, want.writes_register,
								want.illegal_instruction, got.read_value, got.writes_register,
								got.illegal_instruction);
					end
				end
				results_seen++;
			end

			// one long hold-off fills the block; otherwise short random stalls
			if (long_hold > 0) begin
				long_hold--;
				stall = 1'b1;
			end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				long_hold      = LONG_HOLD - 1;
				stall          = 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				stall = 1'b1;
			end else if (pending_ops.size() > TAIL_OPS && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 11);
				stall    = 1'b1;
			end else begin
				stall = 1'b0;
			end
			rsp_ch.ready <= !stall;
		end
	end

	// Watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("segment_lookaside_buffer test failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
